// ===== src/bus_call_byte_receive_framer_macros.svh =====
// Assertion macros used by the checker file of the receive framer.
`ifndef BUS_CALL_BYTE_RECEIVE_FRAMER_MACROS_SVH
`define BUS_CALL_BYTE_RECEIVE_FRAMER_MACROS_SVH

// Implication checked in the same cycle, disabled during reset.
`define BCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framer check failed");

// Implication whose consequence is checked in the next cycle, disabled during reset.
`define BCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framer check failed");

// Implication whose consequence is checked in the next cycle, active during reset as well.
`define BCF_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("framer check failed");

`endif

// ===== src/bcf_pkg.sv =====
// Types and constants shared by the receive framer modules.
`timescale 1ns / 1ps
package bcf_pkg;

  localparam int CNT_W = 5;

  localparam logic [2:0] EV_BYTE       = 3'd0;
  localparam logic [2:0] EV_INQ        = 3'd1;
  localparam logic [2:0] EV_INQ_OK     = 3'd2;
  localparam logic [2:0] EV_ACK        = 3'd3;
  localparam logic [2:0] EV_XOR        = 3'd4;
  localparam logic [2:0] EV_STATION_TO = 3'd5;
  localparam logic [2:0] EV_SLOT_LOST  = 3'd6;

  localparam logic [1:0] CFG_OWN_ADDR  = 2'd0;
  localparam logic [1:0] CFG_CHAR_TO   = 2'd1;
  localparam logic [1:0] CFG_SLOT_TO   = 2'd2;
  localparam logic [1:0] CFG_SLOT_LTO  = 2'd3;

  localparam logic [1:0] KIND_ACK      = 2'b00;
  localparam logic [1:0] KIND_INQ      = 2'b10;

  localparam logic [7:0] BC_CALL       = 8'h60;
  localparam logic [7:0] BC_HEADER     = 8'h61;
  localparam logic [7:0] BC_PROG_ON    = 8'h02;
  localparam logic [7:0] BC_PROG_OFF   = 8'h01;

  localparam logic [3:0]  CHAR_TMR_MAX = 4'hF;
  localparam logic [13:0] SLOT_TMR_MAX = 14'h3FFF;

  // One request from the classifier to the output sequencer.
  typedef struct packed {
    logic             is_dump;  // emit stored message bytes 1..cnt
    logic [2:0]       ev;       // event code for a single result
    logic [CNT_W-1:0] cnt;      // index of the last stored byte to emit
  } cmd_t;

endpackage

// ===== src/bcf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/bcf_cmd_fifo.sv =====
// Two-entry request queue between the classifier and the output sequencer.
`timescale 1ns / 1ps
module bcf_cmd_fifo
  import bcf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t data
);

  cmd_t       entry_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    fill_nxt = fill_r;
    if (push) begin
      wptr_nxt = ~wptr_r;
    end
    if (pop) begin
      rptr_nxt = ~rptr_r;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_data;
    end
  end

  assign full  = fill_r[1];
  assign valid = (fill_r != 2'd0);
  assign data  = entry_r[rptr_r];

endmodule

// ===== src/bcf_front.sv =====
// Classifier: accepts characters and ticks, keeps bus state, stores message bytes.
`timescale 1ns / 1ps
module bcf_front
  import bcf_pkg::*;
#(
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [15:0]   in_tdata,
  input  logic [1:0]    in_tuser,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_addr,
  input  logic [13:0]   cfg_wdata,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata,
  output logic          cmd_push,
  output cmd_t          cmd_data,
  input  logic          q_full,
  input  logic          dump_done
);

  logic [4:0]       own_addr_r;
  logic [3:0]       char_to_r;
  logic [13:0]      slot_to_r;
  logic [13:0]      slot_lto_r;

  logic             recv_r, recv_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [3:0]       char_tmr_r, char_tmr_nxt;
  logic [13:0]      slot_tmr_r, slot_tmr_nxt;
  logic             slot_err_r, slot_err_nxt;
  logic             prog_r, prog_nxt;
  logic             longer_r, longer_nxt;
  logic             dump_pend_r, dump_pend_nxt;
  logic [7:0]       b0_r, b0_nxt;
  logic [7:0]       b1_r, b1_nxt;
  logic [7:0]       b2_r, b2_nxt;

  logic             accept;
  logic             is_tick, is_call, host;
  logic [7:0]       d;
  logic [3:0]       char_inc;
  logic [13:0]      slot_inc;
  logic [CNT_W-1:0] msg_len;
  logic [7:0]       third;
  logic [7:0]       xor_new;

  assign in_tready = !q_full && !dump_pend_r;
  assign accept    = in_tvalid && in_tready;
  assign is_tick   = in_tuser[0];
  assign is_call   = in_tuser[1];
  assign d         = in_tdata[7:0];
  assign host      = in_tdata[8];

  assign char_inc  = (char_tmr_r != CHAR_TMR_MAX) ? char_tmr_r + 4'd1 : char_tmr_r;
  assign slot_inc  = (slot_tmr_r != SLOT_TMR_MAX) ? slot_tmr_r + 14'd1 : slot_tmr_r;
  assign msg_len   = {1'b0, b1_r[3:0]} + CNT_W'(3);
  assign third     = (count_r == CNT_W'(2)) ? d : b2_r;
  assign xor_new   = xor_r ^ d;

  assign ram_we    = accept && !is_tick && !is_call && recv_r;
  assign ram_waddr = AW'(count_r);
  assign ram_wdata = d;

  always_comb begin
    recv_nxt      = recv_r;
    count_nxt     = count_r;
    xor_nxt       = xor_r;
    char_tmr_nxt  = char_tmr_r;
    slot_tmr_nxt  = slot_tmr_r;
    slot_err_nxt  = slot_err_r;
    prog_nxt      = prog_r;
    longer_nxt    = longer_r;
    b0_nxt        = b0_r;
    b1_nxt        = b1_r;
    b2_nxt        = b2_r;
    dump_pend_nxt = dump_pend_r && !dump_done;
    cmd_push      = 1'b0;
    cmd_data      = '0;

    if (accept) begin
      if (is_tick) begin
        char_tmr_nxt = char_inc;
        slot_tmr_nxt = slot_inc;
        if (recv_r && char_inc >= char_to_r) begin
          recv_nxt     = 1'b0;
          count_nxt    = '0;
          char_tmr_nxt = '0;
          cmd_push     = host;
          cmd_data.ev  = EV_STATION_TO;
        end else if (!slot_err_r && ((slot_inc >= slot_to_r && !longer_r) ||
                                     slot_inc >= slot_lto_r)) begin
          slot_err_nxt = 1'b1;
          recv_nxt     = 1'b0;
          count_nxt    = '0;
          cmd_push     = host;
          cmd_data.ev  = EV_SLOT_LOST;
        end
      end else begin
        char_tmr_nxt = '0;
        if (is_call) begin
          // Only our own or the broadcast address, and only with even parity.
          if ((d[4:0] == own_addr_r || d[4:0] == 5'd0) && !(^d)) begin
            case (d[6:5])
              KIND_INQ: begin
                cmd_push     = 1'b1;
                cmd_data.ev  = (slot_tmr_r >= slot_to_r && host) ? EV_INQ_OK : EV_INQ;
                slot_err_nxt = 1'b0;
                longer_nxt   = prog_r;
                slot_tmr_nxt = '0;
              end
              KIND_ACK: begin
                cmd_push    = 1'b1;
                cmd_data.ev = EV_ACK;
              end
              default: begin
                if (recv_r) begin
                  recv_nxt    = 1'b0;
                  count_nxt   = '0;
                  cmd_push    = host;
                  cmd_data.ev = EV_STATION_TO;
                end
                if (host) begin
                  recv_nxt  = 1'b1;
                  count_nxt = CNT_W'(1);
                  xor_nxt   = '0;
                  b0_nxt    = d;
                end
              end
            endcase
          end
        end else if (recv_r) begin
          count_nxt = count_r + CNT_W'(1);
          xor_nxt   = xor_new;
          if (count_r == CNT_W'(1)) begin
            b1_nxt = d;
          end
          if (count_r == CNT_W'(2)) begin
            b2_nxt = d;
          end
          // The length is known once the second byte is stored.
          if (count_r >= CNT_W'(2) && (count_r + CNT_W'(1)) >= msg_len) begin
            recv_nxt  = 1'b0;
            count_nxt = '0;
            cmd_push  = 1'b1;
            if (xor_new != 8'd0) begin
              cmd_data.ev = EV_XOR;
            end else begin
              cmd_data.is_dump = 1'b1;
              cmd_data.ev      = EV_BYTE;
              cmd_data.cnt     = count_r;
              dump_pend_nxt    = 1'b1;
              if (b0_r == BC_CALL && b1_r == BC_HEADER) begin
                if (third == BC_PROG_ON) begin
                  prog_nxt   = 1'b1;
                  longer_nxt = 1'b1;
                end else if (third == BC_PROG_OFF) begin
                  prog_nxt   = 1'b0;
                  longer_nxt = 1'b0;
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r  <= 5'd1;
      char_to_r   <= 4'd2;
      slot_to_r   <= 14'd500;
      slot_lto_r  <= 14'd9000;
      recv_r      <= 1'b0;
      count_r     <= '0;
      xor_r       <= '0;
      char_tmr_r  <= '0;
      slot_tmr_r  <= '0;
      slot_err_r  <= 1'b1;
      prog_r      <= 1'b0;
      longer_r    <= 1'b0;
      dump_pend_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_OWN_ADDR: own_addr_r <= cfg_wdata[4:0];
          CFG_CHAR_TO:  char_to_r  <= cfg_wdata[3:0];
          CFG_SLOT_TO:  slot_to_r  <= cfg_wdata;
          CFG_SLOT_LTO: slot_lto_r <= cfg_wdata;
          default: ;
        endcase
      end
      recv_r      <= recv_nxt;
      count_r     <= count_nxt;
      xor_r       <= xor_nxt;
      char_tmr_r  <= char_tmr_nxt;
      slot_tmr_r  <= slot_tmr_nxt;
      slot_err_r  <= slot_err_nxt;
      prog_r      <= prog_nxt;
      longer_r    <= longer_nxt;
      dump_pend_r <= dump_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b0_r <= b0_nxt;
    b1_r <= b1_nxt;
    b2_r <= b2_nxt;
  end

endmodule

// ===== src/bcf_back.sv =====
// Output sequencer: turns queued requests into result items, reading message bytes.
`timescale 1ns / 1ps
module bcf_back
  import bcf_pkg::*;
#(
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  cmd_t          q_data,
  output logic          q_pop,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  input  logic [7:0]    ram_rdata,
  output logic          dump_done,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic [2:0]    out_tuser,
  output logic          out_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic [2:0]       out_ev_r, out_ev_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign ram_re    = (state_r == ST_READ);
  assign ram_raddr = AW'(idx_r);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_ev_nxt    = out_ev_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    dump_done     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_data.is_dump) begin
            cnt_nxt   = q_data.cnt;
            idx_nxt   = CNT_W'(1);
            state_nxt = ST_READ;
          end else begin
            out_valid_nxt = 1'b1;
            out_ev_nxt    = q_data.ev;
            out_byte_nxt  = 8'd0;
            out_last_nxt  = 1'b1;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // Read data holds until the next read, so a stalled output just waits here.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = EV_BYTE;
          out_byte_nxt  = ram_rdata;
          out_last_nxt  = (idx_r == cnt_r);
          if (idx_r == cnt_r) begin
            dump_done = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_ev_r   <= out_ev_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_ev_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== src/bus_call_byte_receive_framer.sv =====
// A single result (inquiry, ack, error, timeout) passes from the request queue into the output
// register. A message is emitted from the message RAM after its last character is accepted; the
// sequencer reads each byte through its READ and LOAD states, paced by the registered read.
// Requests are taken every cycle, except while the two-entry request queue is full or a message
// dump of N bytes runs (N <= 17).
// Reset is synchronous and restores control state and configuration; the message RAM is not cleared.
`timescale 1ns / 1ps
module bus_call_byte_receive_framer
  import bcf_pkg::*;
#(
  parameter int STORE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] char_data, [8] host_ready, [15:9] zero
  input  logic [1:0]  in_tuser,   // [0] action, [1] ninth_bit
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] message_byte
  output logic [2:0]  out_tuser,  // [2:0] event_res
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [13:0] cfg_wdata
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          cmd_push;
  cmd_t          cmd_wr;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  cmd_t          cmd_rd;
  logic          dump_done;

  bcf_front #(.AW(AW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_wr),
    .q_full    (q_full),
    .dump_done (dump_done)
  );

  bcf_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_wr),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (cmd_rd)
  );

  bcf_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bcf_back #(.AW(AW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (cmd_rd),
    .q_pop      (q_pop),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .dump_done  (dump_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== src/bcf_checker.sv =====
// Port-level checks on the receive framer's result stream, bound to the top level.
`timescale 1ns / 1ps
`include "bus_call_byte_receive_framer_macros.svh"
module bcf_checker
  import bcf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser,
  input logic       out_tlast
);

  // A stalled result must hold.
  `BCF_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // Only message bytes carry data.
  `BCF_ASSERT_IMP(a_byte_zero, clk, rst_n, out_tvalid && out_tuser != EV_BYTE, out_tdata == 8'd0)

  // Any result other than a message byte is the only result of its request.
  `BCF_ASSERT_IMP(a_event_last, clk, rst_n, out_tvalid && out_tuser != EV_BYTE, out_tlast)

  // Reset empties the output register.
  `BCF_ASSERT_NXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid)

endmodule

bind bus_call_byte_receive_framer bcf_checker u_bcf_checker (.*);
